// ----- sv/ace_pkg.sv -----
// types and constants shared by the accumulator core execute unit
// depends on nothing; used by the top level
`timescale 1ns / 1ps
`default_nettype none

package ace_pkg;

	// instruction codes
	typedef enum logic [4:0] {
		OP_NOP = 5'd0,
		OP_SYN = 5'd1,
		OP_CTC = 5'd2,
		OP_CTV = 5'd3,
		OP_DBG = 5'd4,
		OP_HCF = 5'd5,
		OP_HLT = 5'd6,
		OP_MXD = 5'd7,
		OP_MXL = 5'd8,
		OP_MXA = 5'd9,
		OP_MXS = 5'd10,
		OP_MUX = 5'd11,
		OP_MXR = 5'd12,
		OP_LCL = 5'd13,
		OP_LCH = 5'd14,
		OP_JLZ = 5'd15,
		OP_JEZ = 5'd16,
		OP_JGZ = 5'd17,
		OP_JMP = 5'd18,
		OP_LSL = 5'd19,
		OP_LSR = 5'd20,
		OP_CAD = 5'd21,
		OP_CSU = 5'd22,
		OP_CAN = 5'd23,
		OP_COR = 5'd24
	} opcode_t;

	// reset value of the mux code that MXR adds to its argument
	localparam logic [7:0] MUX_PC_BASE_RST = 8'd8;

	// nibble masks for the nibble loads
	localparam logic [7:0] HI_NIBBLE_MASK = 8'hf0;
	localparam logic [7:0] LO_NIBBLE_MASK = 8'h0f;

	// extended sum range: carry outside -128..255
	localparam int SUM_W = 10;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -10'sd128;
	localparam logic signed [SUM_W-1:0] SUM_MAX = 10'sd255;

	// one decoded instruction
	typedef struct packed {
		logic [4:0] opcode;
		logic [3:0] argument;
		logic [7:0] packed_args;
		logic       preload_valid;
		logic [7:0] preload_value;
		logic       preload_sign;
		logic       unlock;
	} exec_in_t;

	// one execution result
	typedef struct packed {
		logic       advance;
		logic [7:0] acc_out;
		logic       negative_out;
		logic       carry_out;
		logic       ctc_out;
		logic [7:0] mux_out;
		logic [3:0] bank_out;
		logic       pc_clear;
		logic       sync_request;
		logic       halted;
	} exec_out_t;

endpackage

`default_nettype wire

// ----- sv/ace_item_if.sv -----
// valid/ready item channel with a typed payload
// depends on nothing; payload types come from ace_pkg at the point of use
`timescale 1ns / 1ps
`default_nettype none

interface ace_item_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/accumulator_core_execute.sv -----
// execute unit of the 8-bit accumulator core: input register, decode and
// execute logic, result register; depends on ace_pkg and ace_item_if
`timescale 1ns / 1ps
`default_nettype none

// Executes one decoded instruction per item against the accumulator, the
// negative/carry/ctc flags, the mux selector and the memory bank, and returns
// exactly one result item per instruction. An item sits in the input register,
// where the whole instruction is executed by combinational logic, and is then
// held in the result register until taken; a new item is accepted every cycle
// as long as results are taken. The internal state is updated when an item
// moves into the result register, so each instruction sees the effect of the
// one before. mux_pc_base is written through cfg_we/cfg_data and must only
// change while no item is in flight.
module accumulator_core_execute (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	ace_item_if.sink        instr,
	ace_item_if.source      result
);

	// configuration register
	logic [7:0] mux_pc_base_q;

	// architectural state
	logic [7:0] acc_q;
	logic       neg_q;
	logic       carry_q;
	logic       ctc_q;
	logic [7:0] mux_q;
	logic [3:0] bank_q;

	// input register
	logic            valid_s1;
	ace_pkg::exec_in_t item_s1;

	// result register
	logic             out_valid_q;
	ace_pkg::exec_out_t out_q;

	// execute results
	ace_pkg::exec_out_t res;
	logic               move_s1;

	// arithmetic operands
	logic signed [ace_pkg::SUM_W-1:0] op_a;
	logic signed [ace_pkg::SUM_W-1:0] op_b;
	logic signed [ace_pkg::SUM_W-1:0] sum;
	logic                             do_sub;
	logic [8:0]                       shl_wide;
	logic [8:0]                       shr_wide;
	logic                             jump;

	// handshake: input register moves on when the result slot frees up
	assign move_s1     = valid_s1 && (!out_valid_q || result.ready);
	assign instr.ready = !valid_s1 || move_s1;
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_pc_base_q <= ace_pkg::MUX_PC_BASE_RST;
		end else if (cfg_we) begin
			mux_pc_base_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (instr.valid && instr.ready) begin
			item_s1 <= instr.payload;
		end
	end

	// operands for add and subtract: accumulator signed when negative is set
	always_comb begin
		op_a = {{2{neg_q & acc_q[7]}}, acc_q};
		do_sub = 1'b0;
		if (item_s1.opcode == ace_pkg::OP_MXA || item_s1.opcode == ace_pkg::OP_MXS) begin
			op_b = {{2{item_s1.preload_sign & item_s1.preload_value[7]}},
				item_s1.preload_value};
			do_sub = (item_s1.opcode == ace_pkg::OP_MXS);
		end else begin
			op_b = {6'd0, item_s1.argument};
			do_sub = (item_s1.opcode == ace_pkg::OP_CSU);
		end
		sum = do_sub ? (op_a - op_b) : (op_a + op_b);
	end

	// shifts: carry from the widened left shift or the last bit shifted out
	assign shl_wide = {1'b0, acc_q} << item_s1.argument;
	assign shr_wide = {acc_q, 1'b0} >> item_s1.argument;

	// instruction execute
	always_comb begin
		res.advance      = 1'b1;
		res.acc_out      = acc_q;
		res.negative_out = neg_q;
		res.carry_out    = carry_q;
		res.ctc_out      = ctc_q;
		res.mux_out      = mux_q;
		res.bank_out     = bank_q;
		res.pc_clear     = 1'b0;
		res.sync_request = 1'b0;
		res.halted       = 1'b0;
		jump             = 1'b0;

		unique case (item_s1.opcode)
			ace_pkg::OP_SYN: begin
				if (!item_s1.unlock) begin
					res.sync_request = 1'b1;
					res.advance      = 1'b0;
				end
			end
			ace_pkg::OP_CTC: res.ctc_out = 1'b1;
			ace_pkg::OP_CTV: res.ctc_out = 1'b0;
			ace_pkg::OP_HLT: begin
				res.halted  = 1'b1;
				res.advance = 1'b0;
			end
			ace_pkg::OP_MXD: res.advance = item_s1.preload_valid;
			ace_pkg::OP_MXL: begin
				res.advance = item_s1.preload_valid;
				if (item_s1.preload_valid) begin
					res.acc_out      = item_s1.preload_value;
					res.negative_out = item_s1.preload_sign;
					res.carry_out    = 1'b0;
				end
			end
			ace_pkg::OP_MXA, ace_pkg::OP_MXS: begin
				res.advance = item_s1.preload_valid;
				if (item_s1.preload_valid) begin
					res.carry_out    = (sum < ace_pkg::SUM_MIN) || (sum > ace_pkg::SUM_MAX);
					res.negative_out = sum[ace_pkg::SUM_W-1];
					res.acc_out      = sum[7:0];
				end
			end
			ace_pkg::OP_CAD, ace_pkg::OP_CSU: begin
				res.carry_out    = (sum < ace_pkg::SUM_MIN) || (sum > ace_pkg::SUM_MAX);
				res.negative_out = sum[ace_pkg::SUM_W-1];
				res.acc_out      = sum[7:0];
			end
			ace_pkg::OP_MUX: res.mux_out = item_s1.packed_args;
			ace_pkg::OP_MXR: res.mux_out = {4'd0, item_s1.argument} + mux_pc_base_q;
			ace_pkg::OP_LCL: res.acc_out = (acc_q & ace_pkg::HI_NIBBLE_MASK)
				| {4'd0, item_s1.argument};
			ace_pkg::OP_LCH: res.acc_out = {item_s1.argument, 4'd0}
				| (acc_q & ace_pkg::LO_NIBBLE_MASK);
			ace_pkg::OP_JLZ: jump = neg_q;
			ace_pkg::OP_JEZ: jump = (acc_q == 8'd0);
			ace_pkg::OP_JGZ: jump = !neg_q && (acc_q != 8'd0);
			ace_pkg::OP_JMP: jump = 1'b1;
			ace_pkg::OP_LSL: begin
				res.carry_out = shl_wide[8];
				res.acc_out   = shl_wide[7:0];
			end
			ace_pkg::OP_LSR: begin
				res.carry_out = shr_wide[0];
				res.acc_out   = shr_wide[8:1];
			end
			ace_pkg::OP_CAN: res.acc_out = acc_q & {4'd0, item_s1.argument};
			ace_pkg::OP_COR: res.acc_out = acc_q | {4'd0, item_s1.argument};
			default: begin
				// nop, debug, hcf and unused codes change nothing
			end
		endcase

		// taken jump: switch bank and restart the pc
		if (jump) begin
			res.bank_out = item_s1.argument;
			res.pc_clear = 1'b1;
			res.advance  = 1'b0;
		end
	end

	// state update and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			neg_q       <= 1'b0;
			carry_q     <= 1'b0;
			ctc_q       <= 1'b0;
			mux_q       <= '0;
			bank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (move_s1) begin
				acc_q   <= res.acc_out;
				neg_q   <= res.negative_out;
				carry_q <= res.carry_out;
				ctc_q   <= res.ctc_out;
				mux_q   <= res.mux_out;
				bank_q  <= res.bank_out;
			end
			if (move_s1) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_q <= res;
		end
	end

	// the held result always matches the state it left behind
	a_state_matches_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (acc_q == out_q.acc_out && mux_q == out_q.mux_out
			&& bank_q == out_q.bank_out && neg_q == out_q.negative_out))
		else $error("state differs from the held result");

	// jump, sync and halt indications never combine and never advance
	a_one_indication: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($onehot0({out_q.pc_clear, out_q.sync_request, out_q.halted})
			&& !((out_q.pc_clear || out_q.sync_request || out_q.halted) && out_q.advance)))
		else $error("conflicting result indications");

	// input only stalls when both registers hold an item and the output waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!instr.ready |-> (valid_s1 && out_valid_q && !result.ready))
		else $error("input stalled without a full pipeline");

	// an item moved out of the input register appears on the result next cycle
	a_move_shows: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> out_valid_q)
		else $error("moved item missing from the result register");

endmodule

`default_nettype wire
